// ----- sv/btdq_pkg.sv -----
// Shared constants and request/result types for the two-part deque.
`timescale 1ns / 1ps

package btdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 8;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_ENQ   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic [1:0]        status;
    } rsp_t;

endpackage

// ----- sv/btdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module btdq_ram
    import btdq_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/bounded_two_part_deque.sv -----
// Top level: two-part byte deque with a move sequencer over two RAMs.
`timescale 1ns / 1ps

// Byte deque built from a stack half and a queue half, each DEPTH entries.
// A request (op, value_in) is taken on a clock edge with start high and busy
// low. Exactly one result (value_out, status) follows, shown on result for a
// single cycle with done high; the receiver cannot stall, so it must take it.
// Clear, refused push/enqueue and pop on empty answer straight from idle.
// Push/enqueue with room writes in S_PUT; a pop reads in S_FETCH, and a pop
// from the queue half then shifts each remaining queue entry down one place.
// Push/enqueue into a full half shifts the other half's entries up, moves
// (DEPTH - other count + 1)/2 entries across, compacts the full half, then
// writes in S_PUT: other half count + DEPTH moves in all. All entry moves go
// through one read/write path shared by both RAMs, one entry at a time (read,
// then write), so the move count sets how long a request takes. busy stays
// high until the result cycle, in which a new request may already be taken.
// Reset empties both halves; RAM contents are not cleared and need no pass.
module bounded_two_part_deque
    import btdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t cmd,
    output logic busy,
    output logic done,
    output rsp_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_WR    = 5'b00100,
        S_PUT   = 5'b01000,
        S_FETCH = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        P_SHIFT   = 4'b0001,
        P_XFER    = 4'b0010,
        P_COMPACT = 4'b0100,
        P_QSHIFT  = 4'b1000
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic              dir_reg, dir_next;
    logic              popq_reg, popq_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]     scnt_reg, scnt_next;
    logic [CW-1:0]     qcnt_reg, qcnt_next;
    logic [CW-1:0]     d_reg, d_next;
    logic [CW-1:0]     mv_reg, mv_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              done_reg, done_next;
    rsp_t              res_reg, res_next;

    logic              accept;
    logic              is_enq;
    logic [CW-1:0]     src_cnt;
    logic [CW-1:0]     dst_cnt;
    logic [CW:0]       span;
    logic [CW-1:0]     mv_calc;
    logic [CW-1:0]     mrd_full;
    logic [CW-1:0]     mwr_full;
    logic              rd_q;
    logic              wr_q;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] s_rdata;
    logic [DATA_W-1:0] q_rdata;
    logic [DATA_W-1:0] fetch_val;
    logic              s_we;
    logic              q_we;

    assign accept  = start && (state_reg == S_IDLE);
    assign is_enq  = (cmd.op == OP_ENQ);
    assign src_cnt = is_enq ? qcnt_reg : scnt_reg;
    assign dst_cnt = is_enq ? scnt_reg : qcnt_reg;
    assign span    = {1'b0, DEPTH_C} - {1'b0, dst_cnt} + (CW+1)'(1);
    assign mv_calc = CW'(span >> 1);

    // Shared address unit for every entry move
    always_comb
    begin
        mrd_full = '0;
        mwr_full = '0;
        rd_q     = 1'b0;
        wr_q     = 1'b0;
        unique case (phase_reg)
            P_SHIFT:
            begin
                mrd_full = d_reg - CW'(1) - idx_reg;
                mwr_full = mrd_full + mv_reg;
                rd_q     = !dir_reg;
                wr_q     = !dir_reg;
            end
            P_XFER:
            begin
                mrd_full = mv_reg - CW'(1) - idx_reg;
                mwr_full = idx_reg;
                rd_q     = dir_reg;
                wr_q     = !dir_reg;
            end
            P_COMPACT:
            begin
                mrd_full = idx_reg + mv_reg;
                mwr_full = idx_reg;
                rd_q     = dir_reg;
                wr_q     = dir_reg;
            end
            P_QSHIFT:
            begin
                mrd_full = idx_reg + CW'(1);
                mwr_full = idx_reg;
                rd_q     = 1'b1;
                wr_q     = 1'b1;
            end
            default:
            begin
                mrd_full = '0;
                mwr_full = '0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = (scnt_reg != '0) ? AW'(scnt_reg - CW'(1)) : '0;
        end
        else
        begin
            rd_addr = AW'(mrd_full);
        end
        if (state_reg == S_PUT)
        begin
            wr_addr = dir_reg ? AW'(qcnt_reg) : AW'(scnt_reg);
            wr_data = val_reg;
        end
        else
        begin
            wr_addr = AW'(mwr_full);
            wr_data = rd_q ? q_rdata : s_rdata;
        end
    end

    assign s_we = ((state_reg == S_WR) && !wr_q) || ((state_reg == S_PUT) && !dir_reg);
    assign q_we = ((state_reg == S_WR) && wr_q) || ((state_reg == S_PUT) && dir_reg);
    assign fetch_val = popq_reg ? q_rdata : s_rdata;

    btdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (s_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (s_rdata)
    );

    btdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (q_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        dir_next   = dir_reg;
        popq_next  = popq_reg;
        val_next   = val_reg;
        scnt_next  = scnt_reg;
        qcnt_next  = qcnt_reg;
        d_next     = d_reg;
        mv_next    = mv_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op) inside
                        OP_CLEAR:
                        begin
                            scnt_next          = '0;
                            qcnt_next          = '0;
                            res_next.value_out = '0;
                            res_next.status    = ST_OK;
                            done_next          = 1'b1;
                        end
                        OP_POP:
                        begin
                            if (scnt_reg != '0)
                            begin
                                scnt_next  = scnt_reg - CW'(1);
                                popq_next  = 1'b0;
                                state_next = S_FETCH;
                            end
                            else if (qcnt_reg != '0)
                            begin
                                qcnt_next  = qcnt_reg - CW'(1);
                                popq_next  = 1'b1;
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                res_next.value_out = '0;
                                res_next.status    = ST_EMPTY;
                                done_next          = 1'b1;
                            end
                        end
                        OP_PUSH, OP_ENQ:
                        begin
                            dir_next = is_enq;
                            val_next = cmd.value_in;
                            if (src_cnt != DEPTH_C)
                            begin
                                state_next = S_PUT;
                            end
                            else if (dst_cnt == DEPTH_C)
                            begin
                                res_next.value_out = '0;
                                res_next.status    = ST_FULL;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                d_next     = dst_cnt;
                                mv_next    = mv_calc;
                                idx_next   = '0;
                                state_next = S_RD;
                                if (dst_cnt != '0)
                                begin
                                    phase_next = P_SHIFT;
                                    n_next     = dst_cnt;
                                end
                                else
                                begin
                                    phase_next = P_XFER;
                                    n_next     = mv_calc;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (idx_reg == n_reg - CW'(1))
                begin
                    idx_next   = '0;
                    state_next = S_RD;
                    unique case (phase_reg)
                        P_SHIFT:
                        begin
                            phase_next = P_XFER;
                            n_next     = mv_reg;
                        end
                        P_XFER:
                        begin
                            phase_next = P_COMPACT;
                            n_next     = DEPTH_C - mv_reg;
                        end
                        P_COMPACT:
                        begin
                            if (dir_reg)
                            begin
                                qcnt_next = DEPTH_C - mv_reg;
                                scnt_next = d_reg + mv_reg;
                            end
                            else
                            begin
                                scnt_next = DEPTH_C - mv_reg;
                                qcnt_next = d_reg + mv_reg;
                            end
                            state_next = S_PUT;
                        end
                        P_QSHIFT:
                        begin
                            res_next.value_out = val_reg;
                            res_next.status    = ST_OK;
                            done_next          = 1'b1;
                            state_next         = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_PUT:
            begin
                if (dir_reg)
                begin
                    qcnt_next = qcnt_reg + CW'(1);
                end
                else
                begin
                    scnt_next = scnt_reg + CW'(1);
                end
                res_next.value_out = val_reg;
                res_next.status    = ST_OK;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            S_FETCH:
            begin
                if (popq_reg && (qcnt_reg != '0))
                begin
                    val_next   = fetch_val;
                    phase_next = P_QSHIFT;
                    n_next     = qcnt_reg;
                    idx_next   = '0;
                    state_next = S_RD;
                end
                else
                begin
                    res_next.value_out = fetch_val;
                    res_next.status    = ST_OK;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_SHIFT;
            scnt_reg  <= '0;
            qcnt_reg  <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            scnt_reg  <= scnt_next;
            qcnt_reg  <= qcnt_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg  <= dir_next;
        popq_reg <= popq_next;
        val_reg  <= val_next;
        d_reg    <= d_next;
        mv_reg   <= mv_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while sequencer busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (scnt_reg <= DEPTH_C) && (qcnt_reg <= DEPTH_C))
        else $error("half count beyond depth");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == OP_CLEAR)) |=>
            (done_reg && (scnt_reg == '0) && (qcnt_reg == '0)))
        else $error("clear did not empty both halves");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> (idx_reg < n_reg))
        else $error("move index past move count");

    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> ((dir_reg ? qcnt_reg : scnt_reg) != DEPTH_C))
        else $error("write into a full half");

endmodule

// ----- bench/bounded_two_part_deque_tb.sv -----
// Self-checking testbench for the two-part byte deque: directed and random requests.
`timescale 1ns / 1ps

module bounded_two_part_deque_tb;
    import btdq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4 * DEPTH + 8;
    localparam int REQ_W          = $bits(req_t);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t result;

    logic [DATA_W-1:0] stk_mem [DEPTH];
    logic [DATA_W-1:0] que_mem [DEPTH];
    int   stk_cnt = 0;
    int   que_cnt = 0;

    rsp_t pending_rsp [$];
    int   err_count    = 0;
    int   stall_cycles = 0;
    bit   idle_en      = 1'b1;

    bounded_two_part_deque #(.DEPTH(DEPTH)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Move the oldest entries of a full half, reversed, to the near end of the other half.
    function automatic bit spill_half(input bit from_stack);
        logic [DATA_W-1:0] src [DEPTH];
        logic [DATA_W-1:0] dst [DEPTH];
        int scnt;
        int dcnt;
        int moved;
        for (int i = 0; i < DEPTH; i++)
        begin
            src[i] = from_stack ? stk_mem[i] : que_mem[i];
            dst[i] = from_stack ? que_mem[i] : stk_mem[i];
        end
        scnt = from_stack ? stk_cnt : que_cnt;
        dcnt = from_stack ? que_cnt : stk_cnt;
        if (scnt < DEPTH)
            return 1'b1;
        if (dcnt >= DEPTH)
            return 1'b0;
        moved = (DEPTH - dcnt + 1) / 2;
        for (int i = dcnt; i > 0; i--)
            dst[i - 1 + moved] = dst[i - 1];
        for (int i = 0; i < moved; i++)
            dst[i] = src[moved - 1 - i];
        for (int i = 0; i + moved < DEPTH; i++)
            src[i] = src[i + moved];
        scnt = DEPTH - moved;
        dcnt = dcnt + moved;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (from_stack)
            begin
                stk_mem[i] = src[i];
                que_mem[i] = dst[i];
            end
            else
            begin
                que_mem[i] = src[i];
                stk_mem[i] = dst[i];
            end
        end
        if (from_stack)
        begin
            stk_cnt = scnt;
            que_cnt = dcnt;
        end
        else
        begin
            que_cnt = scnt;
            stk_cnt = dcnt;
        end
        return 1'b1;
    endfunction

    function automatic rsp_t predict_deque(input req_t r);
        rsp_t rsp;
        rsp.value_out = '0;
        rsp.status    = ST_OK;
        case (r.op)
            OP_PUSH:
            begin
                if (!spill_half(1'b1))
                    rsp.status = ST_FULL;
                else
                begin
                    stk_mem[stk_cnt] = r.value_in;
                    stk_cnt++;
                    rsp.value_out = r.value_in;
                end
            end
            OP_ENQ:
            begin
                if (!spill_half(1'b0))
                    rsp.status = ST_FULL;
                else
                begin
                    que_mem[que_cnt] = r.value_in;
                    que_cnt++;
                    rsp.value_out = r.value_in;
                end
            end
            OP_POP:
            begin
                if (stk_cnt > 0)
                begin
                    stk_cnt--;
                    rsp.value_out = stk_mem[stk_cnt];
                end
                else if (que_cnt > 0)
                begin
                    rsp.value_out = que_mem[0];
                    que_cnt--;
                    for (int i = 0; i < que_cnt; i++)
                        que_mem[i] = que_mem[i + 1];
                end
                else
                    rsp.status = ST_EMPTY;
            end
            default:
            begin
                stk_cnt = 0;
                que_cnt = 0;
            end
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("result with no request pending",
                                    int'(result.value_out), -1);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (result.value_out !== want.value_out)
                        report_mismatch("value_out", int'(result.value_out),
                                        int'(want.value_out));
                    if (result.status !== want.status)
                        report_mismatch("status", int'(result.status), int'(want.status));
                end
            end
            if (start && !busy)
                pending_rsp.push_back(predict_deque(cmd));
            stall_cycles <= ((start && !busy) || done) ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin : watchdog
        do
            @(posedge clk);
        while (stall_cycles < WATCHDOG_LIMIT);
        $display("bounded_two_part_deque test failed");
        $finish;
    end

    task automatic send_req(input logic [1:0] op, input logic [DATA_W-1:0] val);
        req_t r;
        if (idle_en && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            cmd   <= req_t'(REQ_W'($urandom));
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        r.op       = op;
        r.value_in = val;
        start <= 1'b1;
        cmd   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [1:0] pick_op(input int w_push, input int w_enq, input int w_pop);
        int roll;
        roll = $urandom_range(99);
        if (roll < w_push)
            return OP_PUSH;
        if (roll < w_push + w_enq)
            return OP_ENQ;
        if (roll < w_push + w_enq + w_pop)
            return OP_POP;
        return OP_CLEAR;
    endfunction

    task automatic test_basic_ops();
        send_req(OP_POP, 8'h00);
        send_req(OP_PUSH, 8'hFF);
        send_req(OP_ENQ, 8'h00);
        send_req(OP_POP, 8'hFF);
        send_req(OP_POP, 8'h00);
    endtask

    task automatic test_full_halves();
        for (int i = 0; i < DEPTH; i++)
            send_req(OP_PUSH, (i % 2) ? 8'h80 : 8'(8'h01 + i));
        // stack full, queue empty: spill into the queue
        send_req(OP_PUSH, 8'hFF);
        for (int i = 0; i < DEPTH / 2; i++)
            send_req(OP_ENQ, 8'(8'h7F - i));
        for (int i = 0; i < DEPTH / 2 - 1; i++)
            send_req(OP_PUSH, 8'(8'hC0 + i));
        send_req(OP_PUSH, 8'h55);
        send_req(OP_ENQ, 8'hAA);
        send_req(OP_POP, 8'h00);
        // queue full, stack one short: spill into the stack
        send_req(OP_ENQ, 8'h3C);
        send_req(OP_CLEAR, 8'hFF);
        send_req(OP_POP, 8'h00);
    endtask

    task automatic test_random_mixed(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_req(pick_op(35, 30, 30), 8'($urandom_range(255)));
    endtask

    task automatic test_random_drain(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_req(pick_op(20, 20, 55), 8'($urandom_range(255)));
    endtask

    task automatic test_fill_drain_burst(input int n_rounds);
        int n_fill;
        idle_en = 1'b0;
        for (int k = 0; k < n_rounds; k++)
        begin
            n_fill = $urandom_range(2 * DEPTH - 6, 2 * DEPTH + 4);
            for (int i = 0; i < n_fill; i++)
                send_req($urandom_range(1) ? OP_PUSH : OP_ENQ, 8'($urandom_range(255)));
            for (int i = 0; i < n_fill + $urandom_range(0, 2); i++)
                send_req(OP_POP, 8'($urandom_range(255)));
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_full_halves();
        test_random_mixed(850);
        test_random_drain(450);
        test_fill_drain_burst(20);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("bounded_two_part_deque test passed");
        else
            $display("bounded_two_part_deque test failed");
        $finish;
    end

endmodule
